// ===== design/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== design/owbm_pkg.sv =====
package owbm_pkg;

  localparam int TIME_W        = 10;
  localparam int DATA_W        = 8;
  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE + 1);
  localparam int BIT_SEL_W     = $clog2(DATA_W);
  localparam int OP_W          = 2;
  localparam int CFG_IDX_W     = 3;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // command codes
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_RESET = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
  localparam logic [OP_W-1:0] OP_READ  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE0_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LOW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LEN      = 3'd6;

  // register defaults
  localparam logic [TIME_W-1:0] DEF_RESET_LOW     = 10'd480;
  localparam logic [TIME_W-1:0] DEF_PRESENCE_WAIT = 10'd70;
  localparam logic [TIME_W-1:0] DEF_RESET_TAIL    = 10'd55;
  localparam logic [TIME_W-1:0] DEF_WRITE0_LOW    = 10'd60;
  localparam logic [TIME_W-1:0] DEF_SHORT_LOW     = 10'd6;
  localparam logic [TIME_W-1:0] DEF_READ_SAMPLE   = 10'd9;
  localparam logic [TIME_W-1:0] DEF_SLOT_LEN      = 10'd70;

  typedef struct packed {
    logic              line_low;
    logic              busy_res;
    logic              done_res;
    logic [DATA_W-1:0] read_byte;
    logic              presence;
    logic              rejected;
  } rsp_t;

endpackage

// ===== design/owbm_ifs.sv =====
interface owbm_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [owbm_pkg::OP_W-1:0]     op;
  logic [owbm_pkg::DATA_W-1:0]   data_byte;
  logic                          line_level;

  modport source (output valid, op, data_byte, line_level, input ready);
  modport sink (input valid, op, data_byte, line_level, output ready);
endinterface

interface owbm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          line_low;
  logic                          busy_res;
  logic                          done_res;
  logic [owbm_pkg::DATA_W-1:0]   read_byte;
  logic                          presence;
  logic                          rejected;

  modport source (output valid, line_low, busy_res, done_res, read_byte, presence, rejected,
                  input ready);
  modport sink (input valid, line_low, busy_res, done_res, read_byte, presence, rejected,
                output ready);
endinterface

interface owbm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [owbm_pkg::CFG_IDX_W-1:0]   index;
  logic [owbm_pkg::TIME_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/onewire_bus_master.sv =====
// Standard-speed 1-Wire bus master, paced by one-microsecond tick beats.
// cmd channel: each beat is a tick (op=tick, line_level = sampled bus) or a
//   command (reset/presence, write byte, read byte). Commands are taken only
//   while idle; a command that arrives during an operation is dropped and
//   its response has rejected=1.
// rsp channel: exactly one response beat per cmd beat, in order. line_low is
//   the bus drive for the coming microsecond; busy/done/presence/read_byte
//   give status.
// cfg channel: writes the seven timing registers (index 0..6, higher indexes
//   ignored); always ready. Write only while no operation runs.
// Output: each response is registered, into the skid entry if rsp stalls.
// Throughput: one cmd beat per clock while cmd is ready; per-item work is
//   one counter increment and compare plus a small phase machine.
// Stall: a two-entry output stage (register plus skid) keeps cmd ready while
//   one response waits; cmd ready drops only when both entries are full.
// Reset (rst, synchronous): phase idle, counters and flags cleared, timing
//   registers back to their defaults, output stage empty.
`include "assert_macros.svh"

module onewire_bus_master (
  input  logic           clk,
  input  logic           rst,
  owbm_cmd_if.sink       cmd,
  owbm_rsp_if.source     rsp,
  owbm_cfg_if.sink       cfg
);

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_RST_LOW   = 3'd1;
  localparam logic [2:0] PH_RST_WAIT  = 3'd2;
  localparam logic [2:0] PH_RST_TAIL  = 3'd3;
  localparam logic [2:0] PH_SLOT_LOW  = 3'd4;
  localparam logic [2:0] PH_SLOT_REST = 3'd5;

  localparam int TW = owbm_pkg::TIME_W;
  localparam int DW = owbm_pkg::DATA_W;
  localparam int BW = owbm_pkg::BIT_IDX_W;

  // timing registers
  logic [TW-1:0] reset_low_us, presence_wait_us, reset_tail_us;
  logic [TW-1:0] write0_low_us, short_low_us, read_sample_us, slot_len_us;

  // engine state
  logic [2:0]                   phase, phase_next;
  logic [owbm_pkg::OP_W-1:0]    op_kind, op_kind_next;
  logic [TW-1:0]                us_count, us_count_next;
  logic [BW-1:0]                bit_index, bit_index_next;
  logic [DW-1:0]                shift_reg, shift_reg_next;
  logic [DW-1:0]                read_reg, read_reg_next;
  logic                         presence_flag, presence_flag_next;

  // output stage
  owbm_pkg::rsp_t out_q, skid_q, rsp_new;
  logic           out_valid, skid_valid;

  logic          cmd_fire;
  logic [TW-1:0] cnt_inc, slot_low, rest_cnt, rest_end, slot_rest;
  logic [BW-1:0] bit_inc;
  logic          sample_hit, rest_done, byte_end, done, rej;

  assign cfg.ready = 1'b1;
  assign cmd.ready = !skid_valid;
  assign cmd_fire  = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_us     <= owbm_pkg::DEF_RESET_LOW;
      presence_wait_us <= owbm_pkg::DEF_PRESENCE_WAIT;
      reset_tail_us    <= owbm_pkg::DEF_RESET_TAIL;
      write0_low_us    <= owbm_pkg::DEF_WRITE0_LOW;
      short_low_us     <= owbm_pkg::DEF_SHORT_LOW;
      read_sample_us   <= owbm_pkg::DEF_READ_SAMPLE;
      slot_len_us      <= owbm_pkg::DEF_SLOT_LEN;
    end else if (cfg.valid) begin
      case (cfg.index)
        owbm_pkg::CFG_RESET_LOW:     reset_low_us     <= cfg.data;
        owbm_pkg::CFG_PRESENCE_WAIT: presence_wait_us <= cfg.data;
        owbm_pkg::CFG_RESET_TAIL:    reset_tail_us    <= cfg.data;
        owbm_pkg::CFG_WRITE0_LOW:    write0_low_us    <= cfg.data;
        owbm_pkg::CFG_SHORT_LOW:     short_low_us     <= cfg.data;
        owbm_pkg::CFG_READ_SAMPLE:   read_sample_us   <= cfg.data;
        owbm_pkg::CFG_SLOT_LEN:      slot_len_us      <= cfg.data;
        default: ;
      endcase
    end
  end

  // saturating microsecond count
  assign cnt_inc = (us_count == owbm_pkg::TIME_MAX) ? us_count : us_count + TW'(1);

  // slot timing for the current bit
  assign slot_low  = (op_kind == owbm_pkg::OP_WRITE && !shift_reg[0]) ? write0_low_us
                                                                       : short_low_us;
  assign slot_rest = (slot_len_us > slot_low) ? slot_len_us - slot_low : '0;
  assign rest_end  = (op_kind == owbm_pkg::OP_READ && read_sample_us > slot_rest)
                     ? read_sample_us : slot_rest;
  // on the release tick the rest count starts at zero
  assign rest_cnt   = (phase == PH_SLOT_LOW) ? '0 : cnt_inc;
  assign sample_hit = (op_kind == owbm_pkg::OP_READ) && (rest_cnt == read_sample_us);
  assign rest_done  = rest_cnt >= rest_end;
  assign bit_inc    = bit_index + BW'(1);
  assign byte_end   = bit_inc >= BW'(owbm_pkg::BITS_PER_BYTE);

  always_comb begin
    phase_next         = phase;
    op_kind_next       = op_kind;
    us_count_next      = us_count;
    bit_index_next     = bit_index;
    shift_reg_next     = shift_reg;
    read_reg_next      = read_reg;
    presence_flag_next = presence_flag;
    done               = 1'b0;
    rej                = 1'b0;

    if (cmd.op != owbm_pkg::OP_TICK) begin
      if (phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        op_kind_next   = cmd.op;
        us_count_next  = '0;
        bit_index_next = '0;
        if (cmd.op == owbm_pkg::OP_RESET) begin
          presence_flag_next = 1'b0;
          phase_next         = PH_RST_LOW;
        end else begin
          shift_reg_next = (cmd.op == owbm_pkg::OP_WRITE) ? cmd.data_byte : '0;
          if (cmd.op == owbm_pkg::OP_READ) read_reg_next = '0;
          phase_next = PH_SLOT_LOW;
        end
      end
    end else begin
      case (phase)
        PH_IDLE: ;
        PH_RST_LOW: begin
          us_count_next = cnt_inc;
          if (cnt_inc >= reset_low_us) begin
            phase_next    = PH_RST_WAIT;
            us_count_next = '0;
          end
        end
        PH_RST_WAIT: begin
          us_count_next = cnt_inc;
          if (cnt_inc >= presence_wait_us) begin
            presence_flag_next = !cmd.line_level;
            us_count_next      = '0;
            if (reset_tail_us == '0) begin
              phase_next = PH_IDLE;
              done       = 1'b1;
            end else begin
              phase_next = PH_RST_TAIL;
            end
          end
        end
        PH_RST_TAIL: begin
          us_count_next = cnt_inc;
          if (cnt_inc >= reset_tail_us) begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
        end
        PH_SLOT_LOW, PH_SLOT_REST: begin
          us_count_next = cnt_inc;
          if (phase == PH_SLOT_REST || cnt_inc >= slot_low) begin
            phase_next    = PH_SLOT_REST;
            us_count_next = rest_cnt;
            // drop read bits past the byte width
            if (sample_hit && int'(bit_index) < DW)
              read_reg_next[bit_index[owbm_pkg::BIT_SEL_W-1:0]] = cmd.line_level;
            if (rest_done) begin
              bit_index_next = bit_inc;
              shift_reg_next = shift_reg >> 1;
              if (byte_end) begin
                phase_next = PH_IDLE;
                done       = 1'b1;
              end else begin
                phase_next    = PH_SLOT_LOW;
                us_count_next = '0;
              end
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    rsp_new.line_low  = (phase_next == PH_RST_LOW) || (phase_next == PH_SLOT_LOW);
    rsp_new.busy_res  = phase_next != PH_IDLE;
    rsp_new.done_res  = done;
    rsp_new.read_byte = read_reg_next;
    rsp_new.presence  = presence_flag_next;
    rsp_new.rejected  = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      op_kind       <= '0;
      us_count      <= '0;
      bit_index     <= '0;
      shift_reg     <= '0;
      read_reg      <= '0;
      presence_flag <= 1'b0;
    end else if (cmd_fire) begin
      phase         <= phase_next;
      op_kind       <= op_kind_next;
      us_count      <= us_count_next;
      bit_index     <= bit_index_next;
      shift_reg     <= shift_reg_next;
      read_reg      <= read_reg_next;
      presence_flag <= presence_flag_next;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || rsp.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= cmd_fire;
      end
    end else if (cmd_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || rsp.ready) begin
      if (skid_valid) out_q <= skid_q;
      else if (cmd_fire) out_q <= rsp_new;
    end else if (cmd_fire) begin
      skid_q <= rsp_new;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.line_low  = out_q.line_low;
  assign rsp.busy_res  = out_q.busy_res;
  assign rsp.done_res  = out_q.done_res;
  assign rsp.read_byte = out_q.read_byte;
  assign rsp.presence  = out_q.presence;
  assign rsp.rejected  = out_q.rejected;

  `ASSERT_IMPLIES(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `ASSERT_NEXT(a_reject_holds_state, clk, rst,
    cmd_fire && cmd.op != owbm_pkg::OP_TICK && phase != PH_IDLE,
    phase == $past(phase) && us_count == $past(us_count) && bit_index == $past(bit_index))
  `ASSERT_IMPLIES(a_drive_only_busy, clk, rst, out_valid && out_q.line_low, out_q.busy_res)
  `ASSERT_IMPLIES(a_slot_bit_range, clk, rst,
    phase == PH_SLOT_LOW || phase == PH_SLOT_REST,
    bit_index < BW'(owbm_pkg::BITS_PER_BYTE))

endmodule
